// ===== hdl/great_circle_distance_defines.svh =====
// Assertion helpers for the checker file gcd_checker.sv.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// ante implies cons, sampled on clk_i, off while in reset
`define GCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond implies $past(sig, dly) was high
`define GCD_ASSERT_PAST(lbl, cond, sig, dly, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> $past(sig, dly)) \
    else $error(msg);

`endif

// ===== hdl/gcd_pkg.sv =====
`timescale 1ns / 1ps
package gcd_pkg;

  localparam int ANGLE_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 24;

  // internal datapath: signed Q30
  localparam int CW       = 36;
  localparam int SW       = 62;
  localparam int SQ_STEPS = 31;

  localparam logic signed [CW-1:0] ONE_Q30     = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
  localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);

  function automatic logic signed [CW-1:0] gcd_atan(input int i);
    logic signed [CW-1:0] v;
    v = '0;
    unique case (i)
      0:  v = CW'(64'sd843314857);
      1:  v = CW'(64'sd497837829);
      2:  v = CW'(64'sd263043837);
      3:  v = CW'(64'sd133525119);
      4:  v = CW'(64'sd67021712);
      5:  v = CW'(64'sd33543516);
      6:  v = CW'(64'sd16775851);
      7:  v = CW'(64'sd8388437);
      8:  v = CW'(64'sd4194283);
      9:  v = CW'(64'sd2097149);
      10: v = CW'(64'sd1048576);
      default: begin
        if (i <= 30) v = CW'(64'd1 << (30 - i));
      end
    endcase
    return v;
  endfunction

  // pi in the output format
  function automatic logic [63:0] gcd_pi_out(input int angle_width);
    logic [63:0] p;
    p = 64'd3373259426;
    if (angle_width - 3 >= 30) return p << (angle_width - 33);
    return p >> (33 - angle_width);
  endfunction

  function automatic int gcd_latency(input int stages);
    return 2 * stages + SQ_STEPS + 6;
  endfunction

endpackage

// ===== hdl/great_circle_distance.sv =====
`timescale 1ns / 1ps
// Haversine great-circle distance, fully pipelined. One coordinate pair is
// taken on every cycle (busy stays low) and its central angle appears on
// central_angle_o, flagged by done_o for one cycle, once it has passed the
// input and fold registers, the rotation CORDIC stages, three multiply
// stages, 31 square-root steps, the vectoring CORDIC stages and the output
// register. The receiver cannot stall, so results must be
// taken as they come.
module great_circle_distance #(
  parameter int ANGLE_WIDTH   = gcd_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] lat_from_i,
  input  logic signed [ANGLE_WIDTH-1:0] lon_from_i,
  input  logic signed [ANGLE_WIDTH-1:0] lat_to_i,
  input  logic signed [ANGLE_WIDTH-1:0] lon_to_i,
  output logic                          done_o,
  output logic        [ANGLE_WIDTH-2:0] central_angle_o
);
  import gcd_pkg::*;

  localparam int FRAC  = ANGLE_WIDTH - 3;
  localparam int N     = CORDIC_STAGES;
  localparam int LAT   = gcd_latency(N);
  localparam int EW    = ANGLE_WIDTH + 31;
  localparam int RW    = CW + 20;
  localparam int OW    = ANGLE_WIDTH - 1;
  localparam int LSH   = (FRAC <= 30) ? 30 - FRAC : 0;
  localparam int RSH   = (FRAC > 30) ? FRAC - 30 : 0;
  localparam int OSH_L = (FRAC >= 30) ? FRAC - 30 : 0;
  localparam int OSH_R = (FRAC < 30) ? 30 - FRAC : 0;
  localparam logic signed [RW-1:0] PI_OUT = RW'(gcd_pi_out(ANGLE_WIDTH));

  function automatic logic signed [CW-1:0] load(input logic signed [ANGLE_WIDTH-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    e = (e <<< LSH) >>> RSH;
    return CW'(e);
  endfunction

  logic           accept;
  logic [LAT-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // ---- input: load to Q30, half differences
  logic signed [CW-1:0] ang_q [0:3];
  logic signed [CW-1:0] la1, lo1, la2, lo2, dlat, dlon;

  always_comb begin
    la1  = load(lat_from_i);
    lo1  = load(lon_from_i);
    la2  = load(lat_to_i);
    lo2  = load(lon_to_i);
    dlat = la2 - la1;
    dlon = lo2 - lo1;
  end

  always_ff @(posedge clk_i) begin
    ang_q[0] <= dlat >>> 1;
    ang_q[1] <= dlon >>> 1;
    ang_q[2] <= la1;
    ang_q[3] <= la2;
  end

  // ---- rotation CORDIC, four lanes: slat, slon, cos lat1, cos lat2
  logic signed [CW-1:0] rx_q [0:N][0:3];
  logic signed [CW-1:0] ry_q [0:N][0:3];
  logic signed [CW-1:0] rz_q [0:N][0:3];
  logic                 rn_q [0:N][0:3];

  for (genvar k = 0; k < 4; k++) begin : g_fold
    always_ff @(posedge clk_i) begin
      rx_q[0][k] <= GAIN_Q30;
      ry_q[0][k] <= '0;
      priority if (ang_q[k] > HALF_PI_Q30) begin
        rz_q[0][k] <= PI_Q30 - ang_q[k];
        rn_q[0][k] <= 1'b1;
      end else if (ang_q[k] < -HALF_PI_Q30) begin
        rz_q[0][k] <= -PI_Q30 - ang_q[k];
        rn_q[0][k] <= 1'b1;
      end else begin
        rz_q[0][k] <= ang_q[k];
        rn_q[0][k] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    for (genvar k = 0; k < 4; k++) begin : g_lane
      always_ff @(posedge clk_i) begin
        rn_q[i+1][k] <= rn_q[i][k];
        if (!rz_q[i][k][CW-1]) begin
          rx_q[i+1][k] <= rx_q[i][k] - (ry_q[i][k] >>> i);
          ry_q[i+1][k] <= ry_q[i][k] + (rx_q[i][k] >>> i);
          rz_q[i+1][k] <= rz_q[i][k] - gcd_atan(i);
        end else begin
          rx_q[i+1][k] <= rx_q[i][k] + (ry_q[i][k] >>> i);
          ry_q[i+1][k] <= ry_q[i][k] - (rx_q[i][k] >>> i);
          rz_q[i+1][k] <= rz_q[i][k] + gcd_atan(i);
        end
      end
    end
  end

  // ---- haversine term
  logic signed [CW-1:0]   c1, c2, slat, slon;
  logic signed [2*CW-1:0] p_slat, p_slon, p_cc, p_t;
  logic signed [CW-1:0]   slat2_q, slon2_q, cc_q, slat2b_q, t_q;
  logic signed [CW:0]     a_sum;
  logic        [30:0]     a_q;

  always_comb begin
    slat   = ry_q[N][0];
    slon   = ry_q[N][1];
    c1     = rn_q[N][2] ? -rx_q[N][2] : rx_q[N][2];
    c2     = rn_q[N][3] ? -rx_q[N][3] : rx_q[N][3];
    p_slat = slat * slat;
    p_slon = slon * slon;
    p_cc   = c1 * c2;
    p_t    = cc_q * slon2_q;
    a_sum  = (CW+1)'(slat2b_q) + (CW+1)'(t_q);
  end

  always_ff @(posedge clk_i) begin
    slat2_q  <= CW'(p_slat >>> 30);
    slon2_q  <= CW'(p_slon >>> 30);
    cc_q     <= CW'(p_cc >>> 30);
    slat2b_q <= slat2_q;
    t_q      <= CW'(p_t >>> 30);
    priority if (a_sum < 0) begin
      a_q <= '0;
    end else if (a_sum > (CW+1)'(ONE_Q30)) begin
      a_q <= 31'(ONE_Q30);
    end else begin
      a_q <= 31'(a_sum);
    end
  end

  // ---- square roots of a and 1-a (Q60 in, Q30 out), one bit a stage
  logic [SW-1:0] sv_q [1:SQ_STEPS][0:1];
  logic [SW-1:0] sr_q [1:SQ_STEPS][0:1];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_STEPS - 1 - j));
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [SW-1:0] v_in, r_in, trial;
      if (j == 0) begin : g_first
        assign v_in = (k == 0) ? SW'({a_q, 30'b0}) : SW'({31'(ONE_Q30) - a_q, 30'b0});
        assign r_in = '0;
      end else begin : g_next
        assign v_in = sv_q[j][k];
        assign r_in = sr_q[j][k];
      end
      assign trial = r_in + BIT;
      always_ff @(posedge clk_i) begin
        if (v_in >= trial) begin
          sv_q[j+1][k] <= v_in - trial;
          sr_q[j+1][k] <= (r_in >> 1) + BIT;
        end else begin
          sv_q[j+1][k] <= v_in;
          sr_q[j+1][k] <= r_in >> 1;
        end
      end
    end
  end

  // ---- vectoring CORDIC: atan2(sqrt(a), sqrt(1-a))
  logic signed [CW-1:0] vx_q [1:N];
  logic signed [CW-1:0] vy_q [1:N];
  logic signed [CW-1:0] vz_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [CW-1:0] x_in, y_in, z_in;
    if (i == 0) begin : g_first
      assign x_in = CW'(sr_q[SQ_STEPS][1]);
      assign y_in = CW'(sr_q[SQ_STEPS][0]);
      assign z_in = '0;
    end else begin : g_next
      assign x_in = vx_q[i];
      assign y_in = vy_q[i];
      assign z_in = vz_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (!y_in[CW-1]) begin
        vx_q[i+1] <= x_in + (y_in >>> i);
        vy_q[i+1] <= y_in - (x_in >>> i);
        vz_q[i+1] <= z_in + gcd_atan(i);
      end else begin
        vx_q[i+1] <= x_in - (y_in >>> i);
        vy_q[i+1] <= y_in + (x_in >>> i);
        vz_q[i+1] <= z_in - gcd_atan(i);
      end
    end
  end

  // ---- output: double, rescale, clamp to [0, pi]
  logic signed [RW-1:0] res;
  logic        [OW-1:0] out_q;

  always_comb begin
    res = RW'(vz_q[N]) <<< 1;
    res = (res <<< OSH_L) >>> OSH_R;
  end

  always_ff @(posedge clk_i) begin
    priority if (res < 0) begin
      out_q <= '0;
    end else if (res > PI_OUT) begin
      out_q <= OW'(PI_OUT);
    end else begin
      out_q <= OW'(res);
    end
  end

  assign done_o          = vld_q[LAT-1];
  assign central_angle_o = out_q;

endmodule

// ===== hdl/gcd_checker.sv =====
`timescale 1ns / 1ps
`include "great_circle_distance_defines.svh"
module gcd_checker #(
  parameter int ANGLE_WIDTH   = gcd_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic signed [ANGLE_WIDTH-1:0] lat_from_i,
  input logic signed [ANGLE_WIDTH-1:0] lon_from_i,
  input logic signed [ANGLE_WIDTH-1:0] lat_to_i,
  input logic signed [ANGLE_WIDTH-1:0] lon_to_i,
  input logic                          done_o,
  input logic        [ANGLE_WIDTH-2:0] central_angle_o
);
  import gcd_pkg::*;

  localparam int LAT = gcd_latency(CORDIC_STAGES);
  localparam logic [ANGLE_WIDTH-2:0] PI_OUT = (ANGLE_WIDTH-1)'(gcd_pi_out(ANGLE_WIDTH));

  logic acc;
  logic any_in;

  assign acc    = start && !busy;
  assign any_in = ^{lat_from_i, lon_from_i, lat_to_i, lon_to_i} || 1'b1;

  `GCD_ASSERT_IMP(a_beat_out, acc, ##LAT done_o, "accepted beat gave no result")
  `GCD_ASSERT_PAST(a_no_spurious, done_o, acc, LAT, "result without an accepted beat")
  `GCD_ASSERT_IMP(a_range, done_o, central_angle_o <= PI_OUT, "central angle above pi")
  `GCD_ASSERT_IMP(a_never_busy, any_in, !busy, "pipeline raised busy")

endmodule

bind great_circle_distance gcd_checker #(
  .ANGLE_WIDTH  (ANGLE_WIDTH),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_gcd_checker (.*);
